// ===== sv/glze_pkg.sv =====
// Package: shared types and constants of the GIF LZW encoder.
`timescale 1ns / 1ps
`default_nettype none
package glze_pkg;

    localparam int unsigned CODE_W     = 12;
    localparam int unsigned WIDTH_W    = 4;
    localparam int unsigned NFREE_W    = 13;
    localparam int unsigned MAX_WIDTH  = 12;
    localparam int unsigned MAX_CODES  = 4096;
    localparam int unsigned SUB_MAX    = 255;
    localparam int unsigned EPOCH_W    = 8;
    localparam int unsigned KEY_W      = 20;
    localparam int unsigned HASH_W     = 32;
    localparam logic [31:0] HASH_MULT  = 32'd2654435761;
    localparam logic [3:0]  ROOT_MIN   = 4'd2;
    localparam logic [3:0]  ROOT_MAX   = 4'd8;

    typedef enum logic [3:0] {
        S_SWEEP,
        S_IDLE,
        S_DECODE,
        S_OPEN,
        S_END_A,
        S_END_B,
        S_HASH,
        S_HWAIT,
        S_PROBE,
        S_CMP,
        S_MISS,
        S_CLEAR_FULL
    } t_state;

    typedef enum logic [1:0] {
        SEL_PREFIX,
        SEL_CLEAR,
        SEL_EOI
    } t_code_sel;

    typedef struct packed {
        logic latch;
        logic hash_start;
        logic probe_rd;
        logic probe_next;
        logic hit_load;
        logic add_entry;
        logic dict_clear;
        logic prefix_pix;
        logic frame_set;
        logic frame_clr;
    } t_dp_cmd;

    typedef struct packed {
        logic cmd;
        logic in_frame;
        logic hash_done;
        logic tag_valid;
        logic key_match;
        logic dict_full;
        logic sweep_busy;
    } t_dp_sts;

    typedef struct packed {
        logic      send;
        t_code_sel sel;
        logic      last;
        logic      flush;
    } t_pk_req;

    typedef struct packed {
        logic              send;
        logic [CODE_W-1:0] code;
        logic [WIDTH_W-1:0] width;
        logic              last;
        logic              flush;
    } t_code_xfer;

endpackage
`default_nettype wire

// ===== sv/glze_ifs.sv =====
// Interfaces: pixel input, byte output and configuration channels.
`timescale 1ns / 1ps
`default_nettype none
interface glze_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] pixel_index;
    modport source (output valid, cmd, pixel_index, input ready);
    modport sink   (input valid, cmd, pixel_index, output ready);
endinterface

interface glze_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       subblock_end;
    logic [7:0] subblock_len;
    logic       frame_end;
    logic       run_last;
    modport source (output valid, data_byte, subblock_end, subblock_len, frame_end, run_last,
                    input ready);
    modport sink   (input valid, data_byte, subblock_end, subblock_len, frame_end, run_last,
                    output ready);
endinterface

interface glze_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] root_bits;
    modport source (output valid, root_bits, input ready);
    modport sink   (input valid, root_bits, output ready);
endinterface
`default_nettype wire

// ===== sv/glze_ctrl.sv =====
// Controller: sequences lookup, code emission and dictionary maintenance.
`timescale 1ns / 1ps
`default_nettype none
module glze_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire glze_pkg::t_dp_sts i_sts,
    input  wire logic             i_pk_idle,
    output glze_pkg::t_dp_cmd     o_cmd,
    output glze_pkg::t_pk_req     o_pk
);

    glze_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= glze_pkg::S_SWEEP;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            glze_pkg::S_SWEEP: if (!i_sts.sweep_busy) n_state = glze_pkg::S_IDLE;
            glze_pkg::S_IDLE:  if (i_in_valid) n_state = glze_pkg::S_DECODE;
            glze_pkg::S_DECODE: begin
                if (!i_sts.in_frame)  n_state = glze_pkg::S_OPEN;
                else if (i_sts.cmd)   n_state = glze_pkg::S_END_A;
                else                  n_state = glze_pkg::S_HASH;
            end
            glze_pkg::S_OPEN: if (i_pk_idle) begin
                n_state = i_sts.cmd ? glze_pkg::S_END_B : glze_pkg::S_SWEEP;
            end
            glze_pkg::S_END_A: if (i_pk_idle) n_state = glze_pkg::S_END_B;
            glze_pkg::S_END_B: if (i_pk_idle) n_state = glze_pkg::S_SWEEP;
            glze_pkg::S_HASH:  n_state = glze_pkg::S_HWAIT;
            glze_pkg::S_HWAIT: if (i_sts.hash_done) n_state = glze_pkg::S_PROBE;
            glze_pkg::S_PROBE: n_state = glze_pkg::S_CMP;
            glze_pkg::S_CMP: begin
                if (i_sts.tag_valid && i_sts.key_match) n_state = glze_pkg::S_IDLE;
                else if (i_sts.tag_valid)               n_state = glze_pkg::S_PROBE;
                else                                    n_state = glze_pkg::S_MISS;
            end
            glze_pkg::S_MISS: if (i_pk_idle) begin
                n_state = i_sts.dict_full ? glze_pkg::S_CLEAR_FULL : glze_pkg::S_IDLE;
            end
            glze_pkg::S_CLEAR_FULL: if (i_pk_idle) n_state = glze_pkg::S_SWEEP;
            default: n_state = glze_pkg::S_SWEEP;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_pk       = '0;
        o_pk.sel   = glze_pkg::SEL_PREFIX;
        o_in_ready = 1'b0;
        case (r_state)
            glze_pkg::S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.latch = i_in_valid;
            end
            glze_pkg::S_DECODE: o_cmd.dict_clear = !i_sts.in_frame;
            glze_pkg::S_OPEN: if (i_pk_idle) begin
                o_pk.send = 1'b1;
                o_pk.sel  = glze_pkg::SEL_CLEAR;
                o_pk.last = !i_sts.cmd;
                o_cmd.prefix_pix = !i_sts.cmd;
                o_cmd.frame_set  = !i_sts.cmd;
            end
            glze_pkg::S_END_A: if (i_pk_idle) begin
                o_pk.send = 1'b1;
                o_pk.sel  = glze_pkg::SEL_PREFIX;
            end
            glze_pkg::S_END_B: if (i_pk_idle) begin
                o_pk.send  = 1'b1;
                o_pk.sel   = glze_pkg::SEL_EOI;
                o_pk.last  = 1'b1;
                o_pk.flush = 1'b1;
                o_cmd.frame_clr = 1'b1;
            end
            glze_pkg::S_HASH:  o_cmd.hash_start = 1'b1;
            glze_pkg::S_PROBE: o_cmd.probe_rd = 1'b1;
            glze_pkg::S_CMP: begin
                o_cmd.hit_load   = i_sts.tag_valid && i_sts.key_match;
                o_cmd.probe_next = i_sts.tag_valid && !i_sts.key_match;
            end
            glze_pkg::S_MISS: if (i_pk_idle) begin
                o_pk.send = 1'b1;
                o_pk.sel  = glze_pkg::SEL_PREFIX;
                o_pk.last = !i_sts.dict_full;
                o_cmd.add_entry  = !i_sts.dict_full;
                o_cmd.prefix_pix = !i_sts.dict_full;
            end
            glze_pkg::S_CLEAR_FULL: if (i_pk_idle) begin
                // clear code goes out at the old width, then the table restarts
                o_pk.send = 1'b1;
                o_pk.sel  = glze_pkg::SEL_CLEAR;
                o_pk.last = 1'b1;
                o_cmd.dict_clear = 1'b1;
                o_cmd.prefix_pix = 1'b1;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

// ===== sv/glze_dict.sv =====
// Datapath: hashed dictionary memory, hash unit and LZW code state.
`timescale 1ns / 1ps
`default_nettype none
module glze_dict #(
    parameter int unsigned DICT_SLOTS = 8192
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [3:0]         i_cfg_data,
    input  wire logic               i_cmd_bit,
    input  wire logic [7:0]         i_pix,
    input  wire glze_pkg::t_dp_cmd  i_cmd,
    input  wire glze_pkg::t_pk_req  i_pk,
    output glze_pkg::t_dp_sts       o_sts,
    output glze_pkg::t_code_xfer    o_code
);

    localparam int unsigned SW    = $clog2(DICT_SLOTS);
    localparam int unsigned ROW_W = glze_pkg::EPOCH_W + glze_pkg::KEY_W + glze_pkg::CODE_W;
    localparam logic [SW-1:0] LAST_SLOT = SW'(DICT_SLOTS - 1);
    localparam logic [glze_pkg::EPOCH_W-1:0] EPOCH_MAX = '1;

    logic [3:0]                    r_min;
    logic                          r_cmd;
    logic [7:0]                    r_pix;
    logic [glze_pkg::CODE_W-1:0]   r_prefix;
    logic [glze_pkg::NFREE_W-1:0]  r_next_free;
    logic [glze_pkg::WIDTH_W-1:0]  r_width;
    logic                          r_in_frame;
    logic [glze_pkg::EPOCH_W-1:0]  r_epoch;
    logic                          r_sweep_busy;
    logic [SW-1:0]                 r_sweep_addr;
    logic [SW-1:0]                 r_slot;
    logic [ROW_W-1:0]              r_rd;
    logic [ROW_W-1:0]              r_mem [DICT_SLOTS];
    logic [glze_pkg::HASH_W-1:0]   r_prod;
    logic                          r_hash_done;

    logic [3:0]                    m;
    logic [glze_pkg::CODE_W-1:0]   clr_code;
    logic [glze_pkg::KEY_W-1:0]    key;
    logic [glze_pkg::HASH_W-1:0]   prod;
    logic                          mem_we;
    logic [SW-1:0]                 mem_waddr;
    logic [ROW_W-1:0]              mem_wdata;
    logic [glze_pkg::EPOCH_W-1:0]  rd_tag;
    logic [glze_pkg::KEY_W-1:0]    rd_key;
    logic [glze_pkg::CODE_W-1:0]   rd_code;
    logic [SW-1:0]                 hash_slot;
    logic                          hash_fin;

    always_comb begin
        if (r_min < glze_pkg::ROOT_MIN)      m = glze_pkg::ROOT_MIN;
        else if (r_min > glze_pkg::ROOT_MAX) m = glze_pkg::ROOT_MAX;
        else                                 m = r_min;
    end

    assign clr_code = glze_pkg::CODE_W'(1) << m;
    assign key      = {r_prefix, r_pix};
    assign prod     = glze_pkg::HASH_W'({1'b1, key} * glze_pkg::HASH_MULT);
    assign {rd_tag, rd_key, rd_code} = r_rd;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min        <= 4'd8;
            r_in_frame   <= 1'b0;
            r_epoch      <= glze_pkg::EPOCH_W'(1);
            r_sweep_busy <= 1'b1;
            r_sweep_addr <= '0;
            r_prefix     <= '0;
            r_next_free  <= glze_pkg::NFREE_W'(258);
            r_width      <= glze_pkg::WIDTH_W'(9);
        end else begin
            if (i_cfg_we) r_min <= i_cfg_data;
            if (i_cmd.frame_set) r_in_frame <= 1'b1;
            if (i_cmd.frame_clr) r_in_frame <= 1'b0;
            if (r_sweep_busy) begin
                r_sweep_addr <= r_sweep_addr + SW'(1);
                if (r_sweep_addr == LAST_SLOT) r_sweep_busy <= 1'b0;
            end
            if (i_cmd.hit_load)   r_prefix <= rd_code;
            if (i_cmd.prefix_pix) r_prefix <= glze_pkg::CODE_W'(r_pix);
            if (i_cmd.add_entry) begin
                if (r_next_free == (glze_pkg::NFREE_W'(1) << r_width)
                    && r_width < glze_pkg::WIDTH_W'(glze_pkg::MAX_WIDTH)) begin
                    r_width <= r_width + glze_pkg::WIDTH_W'(1);
                end
                r_next_free <= r_next_free + glze_pkg::NFREE_W'(1);
            end
            if (i_cmd.dict_clear) begin
                r_next_free <= glze_pkg::NFREE_W'(clr_code) + glze_pkg::NFREE_W'(2);
                r_width     <= m + 4'd1;
                // epoch wrap: stale tags could alias, so wipe the table
                if (r_epoch == EPOCH_MAX) begin
                    r_epoch      <= glze_pkg::EPOCH_W'(1);
                    r_sweep_busy <= 1'b1;
                    r_sweep_addr <= '0;
                end else begin
                    r_epoch <= r_epoch + glze_pkg::EPOCH_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_cmd <= i_cmd_bit;
            r_pix <= i_pix & 8'(clr_code - glze_pkg::CODE_W'(1));
        end
        if (i_cmd.probe_rd) r_rd <= r_mem[r_slot];
        if (hash_fin) r_slot <= hash_slot;
        else if (i_cmd.probe_next) r_slot <= (r_slot == LAST_SLOT) ? '0 : r_slot + SW'(1);
    end

    // Hash unit: product, then reduction to a slot index
    generate
        if ((DICT_SLOTS & (DICT_SLOTS - 1)) == 0) begin : g_pow2
            logic r_red;
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_red       <= 1'b0;
                    r_hash_done <= 1'b0;
                end else begin
                    r_red <= i_cmd.hash_start;
                    if (i_cmd.hash_start) r_hash_done <= 1'b0;
                    else if (r_red)       r_hash_done <= 1'b1;
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_cmd.hash_start) r_prod <= prod;
            end
            assign hash_fin  = r_red;
            assign hash_slot = r_prod[SW-1:0];
        end else begin : g_recip
            // quotient estimate by reciprocal, low by at most one, then one correcting subtract
            localparam logic [19:0] RECIP   = 20'((64'd1 << 32) / 64'(DICT_SLOTS));
            localparam logic [SW:0] SLOTS_V = (SW+1)'(DICT_SLOTS);
            logic [2:0]  r_hpipe;
            logic [19:0] r_q;
            logic [SW:0] r_rem;
            logic [51:0] qprod;
            logic [35:0] qd;
            logic [31:0] diff;
            assign qprod = 52'(r_prod) * 52'(RECIP);
            assign qd    = 36'(r_q) * 36'(DICT_SLOTS);
            assign diff  = r_prod - qd[31:0];
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_hpipe     <= '0;
                    r_hash_done <= 1'b0;
                end else begin
                    r_hpipe <= {r_hpipe[1:0], i_cmd.hash_start};
                    if (i_cmd.hash_start)  r_hash_done <= 1'b0;
                    else if (r_hpipe[2])   r_hash_done <= 1'b1;
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_cmd.hash_start) r_prod <= prod;
                if (r_hpipe[0])       r_q    <= qprod[51:32];
                if (r_hpipe[1])       r_rem  <= diff[SW:0];
            end
            assign hash_fin  = r_hpipe[2];
            assign hash_slot = (r_rem >= SLOTS_V) ? SW'(r_rem - SLOTS_V) : r_rem[SW-1:0];
        end
    endgenerate

    // Dictionary memory: one write port, one registered read port
    assign mem_we    = r_sweep_busy || i_cmd.add_entry;
    assign mem_waddr = r_sweep_busy ? r_sweep_addr : r_slot;
    assign mem_wdata = r_sweep_busy ? '0
                     : {r_epoch, key, r_next_free[glze_pkg::CODE_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
    end

    always_comb begin
        o_sts.cmd        = r_cmd;
        o_sts.in_frame   = r_in_frame;
        o_sts.hash_done  = r_hash_done;
        o_sts.tag_valid  = (rd_tag == r_epoch);
        o_sts.key_match  = (rd_key == key);
        o_sts.dict_full  = (r_next_free >= glze_pkg::NFREE_W'(glze_pkg::MAX_CODES));
        o_sts.sweep_busy = r_sweep_busy;
    end

    always_comb begin
        o_code.send  = i_pk.send;
        o_code.last  = i_pk.last;
        o_code.flush = i_pk.flush;
        o_code.width = (r_width > glze_pkg::WIDTH_W'(glze_pkg::MAX_WIDTH))
                     ? glze_pkg::WIDTH_W'(glze_pkg::MAX_WIDTH) : r_width;
        case (i_pk.sel)
            glze_pkg::SEL_PREFIX: o_code.code = r_prefix;
            glze_pkg::SEL_CLEAR:  o_code.code = clr_code;
            glze_pkg::SEL_EOI:    o_code.code = clr_code + glze_pkg::CODE_W'(1);
            default:              o_code.code = r_prefix;
        endcase
    end

endmodule
`default_nettype wire

// ===== sv/glze_packer.sv =====
// Bit packer: LSB-first byte packing, sub-block marking and output register.
`timescale 1ns / 1ps
`default_nettype none
module glze_packer (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire glze_pkg::t_code_xfer i_code,
    output logic                      o_idle,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [7:0]                o_data_byte,
    output logic                      o_subblock_end,
    output logic [7:0]                o_subblock_len,
    output logic                      o_frame_end,
    output logic                      o_run_last
);

    logic [18:0] r_acc;
    logic [4:0]  r_cnt;
    logic        r_last;
    logic        r_flush;
    logic [7:0]  r_sub;
    logic        r_ovalid;

    logic [11:0] mask;
    logic [18:0] ins;
    logic        full_byte;
    logic        emit;
    logic [4:0]  rem;
    logic        is_last;
    logic        is_fend;
    logic [7:0]  sub1;
    logic        sb_end;

    assign mask      = 12'((13'd1 << i_code.width) - 13'd1);
    assign ins       = 19'(i_code.code & mask) << r_cnt;
    assign full_byte = (r_cnt >= 5'd8);
    assign emit      = (full_byte || (r_flush && r_cnt != 5'd0)) && (!r_ovalid || i_ready);
    assign rem       = full_byte ? r_cnt - 5'd8 : 5'd0;
    assign is_last   = r_last && (rem < 5'd8) && !(r_flush && rem != 5'd0);
    assign is_fend   = is_last && r_flush;
    assign sub1      = r_sub + 8'd1;
    assign sb_end    = is_fend || (sub1 == 8'(glze_pkg::SUB_MAX));
    assign o_idle    = (r_cnt < 5'd8) && !r_flush;
    assign o_valid   = r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_acc    <= '0;
            r_last   <= 1'b0;
            r_flush  <= 1'b0;
            r_sub    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_code.send) begin
                r_acc   <= r_acc | ins;
                r_cnt   <= r_cnt + 5'(i_code.width);
                r_last  <= i_code.last;
                r_flush <= i_code.flush;
            end else if (emit) begin
                r_acc <= full_byte ? r_acc >> 8 : '0;
                r_cnt <= rem;
                if (rem == 5'd0) r_flush <= 1'b0;
            end
            if (emit) begin
                r_ovalid <= 1'b1;
                r_sub    <= sb_end ? 8'd0 : sub1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            o_data_byte    <= r_acc[7:0];
            o_subblock_end <= sb_end;
            o_subblock_len <= sb_end ? sub1 : 8'd0;
            o_frame_end    <= is_fend;
            o_run_last     <= is_last;
        end
    end

endmodule
`default_nettype wire

// ===== sv/gif_lzw_encoder_top.sv =====
// Top level: GIF LZW image-data encoder with 12-bit maximum code width.
// Items are taken one at a time: a hit runs hash, probe and compare, repeating probe and
//   compare for each extra linear probe step; a miss also waits for the packer to drain.
// The next item is accepted only once the previous one is fully handled.
// Reset: synchronous, active low; a clearing pass over all DICT_SLOTS slots follows it and
//   every 255th dictionary restart.
`timescale 1ns / 1ps
`default_nettype none
module gif_lzw_encoder_top #(
    parameter int unsigned DICT_SLOTS = 8192
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    glze_in_if.sink     i_in,
    glze_out_if.source  o_out,
    glze_cfg_if.sink    i_cfg
);

    glze_pkg::t_dp_cmd    dp_cmd;
    glze_pkg::t_dp_sts    dp_sts;
    glze_pkg::t_pk_req    pk_req;
    glze_pkg::t_code_xfer code_xfer;
    logic                 pk_idle;

    assign i_cfg.ready = 1'b1;

    glze_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (dp_sts),
        .i_pk_idle  (pk_idle),
        .o_cmd      (dp_cmd),
        .o_pk       (pk_req)
    );

    glze_dict #(.DICT_SLOTS(DICT_SLOTS)) u_dict (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg.valid),
        .i_cfg_data (i_cfg.root_bits),
        .i_cmd_bit  (i_in.cmd),
        .i_pix      (i_in.pixel_index),
        .i_cmd      (dp_cmd),
        .i_pk       (pk_req),
        .o_sts      (dp_sts),
        .o_code     (code_xfer)
    );

    glze_packer u_packer (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_code         (code_xfer),
        .o_idle         (pk_idle),
        .o_valid        (o_out.valid),
        .i_ready        (o_out.ready),
        .o_data_byte    (o_out.data_byte),
        .o_subblock_end (o_out.subblock_end),
        .o_subblock_len (o_out.subblock_len),
        .o_frame_end    (o_out.frame_end),
        .o_run_last     (o_out.run_last)
    );

    a_send_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pk_req.send |-> pk_idle)
        else $error("code sent while packer still draining");

    a_no_accept_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !dp_sts.sweep_busy)
        else $error("item accepted during dictionary clearing pass");

    a_frame_end_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.frame_end) |-> (o_out.subblock_end && o_out.run_last))
        else $error("frame end byte does not close sub-block");

endmodule
`default_nettype wire

// ===== sim/glze_tb_ifs_note.sv =====
// Checker: watches the channels, predicts every output byte and counts mismatches.
`timescale 1ns / 1ps
module glze_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    glze_in_if         i_in,
    glze_out_if        i_out,
    glze_cfg_if        i_cfg,
    output int         o_fail_count,
    output int         o_pending
);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       subblock_end;
        logic [7:0] subblock_len;
        logic       frame_end;
        logic       run_last;
    } t_byte_rec;

    localparam int SLOTS = 8192;

    logic [20:0] key_tab [SLOTS];
    logic [11:0] code_tab [SLOTS];
    logic [11:0] prefix;
    logic [12:0] free_code;
    logic [3:0]  width;
    logic [6:0]  held_bits;
    logic [2:0]  held_cnt;
    logic [7:0]  sub_cnt;
    logic        open_frame;
    logic [3:0]  root_reg;
    logic [7:0]  byte_q [$];
    t_byte_rec   byte_expect [$];

    function automatic logic [3:0] root_size();
        if (root_reg < 4'd2) return 4'd2;
        if (root_reg > 4'd8) return 4'd8;
        return root_reg;
    endfunction

    task automatic wipe_dict(input logic [3:0] m);
        for (int i = 0; i < SLOTS; i++) key_tab[i] = '0;
        free_code = (13'd1 << m) + 13'd2;
        width = m + 4'd1;
    endtask

    task automatic pack_code(input logic [11:0] code, input logic [3:0] w);
        logic [31:0] acc;
        int cnt;
        acc = {25'b0, held_bits} | ((32'(code) & ((32'd1 << w) - 1)) << held_cnt);
        cnt = held_cnt + w;
        while (cnt >= 8) begin
            byte_q.push_back(acc[7:0]);
            acc = acc >> 8;
            cnt -= 8;
        end
        held_bits = acc[6:0];
        held_cnt = cnt[2:0];
    endtask

    task automatic encode_item(input logic cmd, input logic [7:0] pix_in);
        logic [3:0]  m;
        logic [11:0] clr, eoi;
        logic [7:0]  pix;
        logic [20:0] key;
        logic [31:0] slot;
        logic        found, have_slot, ending, last_f, closes;
        t_byte_rec   r;
        m = root_size();
        clr = 12'd1 << m;
        eoi = clr + 12'd1;
        pix = pix_in & 8'(clr - 1);
        ending = 0;
        byte_q = {};
        if (!cmd) begin
            if (!open_frame) begin
                wipe_dict(m);
                held_bits = 0; held_cnt = 0; sub_cnt = 0;
                pack_code(clr, width);
                prefix = 12'(pix);
                open_frame = 1;
            end else begin
                key = {1'b1, prefix, pix};
                slot = (32'(key) * 32'd2654435761) % SLOTS;
                found = 0; have_slot = 0;
                for (int n = 0; n < SLOTS; n++) begin
                    if (!key_tab[slot][20]) begin have_slot = 1; break; end
                    if (key_tab[slot] == key) begin found = 1; break; end
                    slot = (slot + 1) % SLOTS;
                end
                if (found) begin
                    prefix = code_tab[slot];
                end else begin
                    pack_code(prefix, width);
                    if (free_code < 4096) begin
                        if (have_slot) begin
                            key_tab[slot] = key;
                            code_tab[slot] = free_code[11:0];
                        end
                        if (free_code == (13'd1 << width) && width < 12) width++;
                        free_code++;
                    end else begin
                        pack_code(clr, width);
                        wipe_dict(m);
                    end
                    prefix = 12'(pix);
                end
            end
        end else begin
            if (!open_frame) begin
                wipe_dict(m);
                held_bits = 0; held_cnt = 0; sub_cnt = 0;
                pack_code(clr, width);
                pack_code(eoi, width);
            end else begin
                pack_code(prefix, width);
                pack_code(eoi, width);
            end
            if (held_cnt > 0) byte_q.push_back({1'b0, held_bits});
            held_bits = 0; held_cnt = 0;
            open_frame = 0;
            ending = 1;
        end
        foreach (byte_q[i]) begin
            last_f = ending && (i == byte_q.size() - 1);
            sub_cnt++;
            closes = last_f || sub_cnt >= 255;
            r.data_byte = byte_q[i];
            r.subblock_end = closes;
            r.subblock_len = closes ? sub_cnt : 8'd0;
            r.frame_end = last_f;
            r.run_last = (i == byte_q.size() - 1);
            byte_expect.push_back(r);
            if (closes) sub_cnt = 0;
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        root_reg = 8;
        wipe_dict(8);
        for (int i = 0; i < SLOTS; i++) code_tab[i] = '0;
        prefix = 0; held_bits = 0; held_cnt = 0; sub_cnt = 0; open_frame = 0;
    end

    always @(posedge i_clk) begin
        t_byte_rec want;
        if (i_rst_n) begin
            if (i_cfg.valid && i_cfg.ready) root_reg = i_cfg.root_bits;
            if (i_out.valid && i_out.ready) begin
                if (byte_expect.size() == 0) begin
                    report_mismatch("unexpected byte", i_out.data_byte, -1);
                end else begin
                    want = byte_expect.pop_front();
                    if (i_out.data_byte != want.data_byte)
                        report_mismatch("data_byte", i_out.data_byte, want.data_byte);
                    if (i_out.subblock_end != want.subblock_end)
                        report_mismatch("subblock_end", i_out.subblock_end, want.subblock_end);
                    if (i_out.subblock_len != want.subblock_len)
                        report_mismatch("subblock_len", i_out.subblock_len, want.subblock_len);
                    if (i_out.frame_end != want.frame_end)
                        report_mismatch("frame_end", i_out.frame_end, want.frame_end);
                    if (i_out.run_last != want.run_last)
                        report_mismatch("run_last", i_out.run_last, want.run_last);
                end
            end
            if (i_in.valid && i_in.ready) encode_item(i_in.cmd, i_in.pixel_index);
        end
        o_pending = byte_expect.size();
    end
endmodule

// ===== sim/tb.sv =====
// Testbench top: drives pixels, frame ends and root size, and gives the verdict.
`timescale 1ns / 1ps
module tb;
    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   cycles;
    int   gap_left;
    logic quiet;

    glze_in_if  in_ch ();
    glze_out_if out_ch ();
    glze_cfg_if cfg_ch ();

    gif_lzw_encoder_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .o_out(out_ch), .i_cfg(cfg_ch)
    );

    glze_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .i_out(out_ch), .i_cfg(cfg_ch),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // timeout: covers the clearing pass, stalls and the longest dictionary probes
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // byte sink with bursty back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 0;
            gap_left <= 0;
        end else if (gap_left > 0) begin
            out_ch.ready <= 0;
            gap_left <= gap_left - 1;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            out_ch.ready <= 0;
            gap_left <= $urandom_range(0, 17);
        end else begin
            out_ch.ready <= 1;
        end
    end

    task automatic send_item(input logic cmd, input logic [7:0] pix);
        if (!quiet && $urandom_range(0, 9) == 0) begin
            in_ch.valid <= 0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        in_ch.valid <= 1;
        in_ch.cmd <= cmd;
        in_ch.pixel_index <= pix;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic drain_all();
        in_ch.valid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_root(input logic [3:0] v);
        drain_all();
        cfg_ch.valid <= 1;
        cfg_ch.root_bits <= v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 0;
    endtask

    // one frame of random pixels; low alphabets give long hit runs
    task automatic send_frame(input int len, input int span);
        for (int i = 0; i < len; i++) send_item(1'b0, 8'($urandom_range(0, span)));
        send_item(1'b1, 8'($urandom));
    endtask

    initial begin
        logic [3:0] roots [6];
        cycles = 0;
        quiet = 0;
        i_rst_n = 0;
        in_ch.valid = 0; in_ch.cmd = 0; in_ch.pixel_index = 0;
        cfg_ch.valid = 0; cfg_ch.root_bits = 0;
        out_ch.ready = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: empty frame, extremes, repeated pixel, masking
        send_item(1'b1, 8'h00);
        send_item(1'b0, 8'hFF);
        send_item(1'b0, 8'h00);
        send_item(1'b0, 8'hFF);
        send_item(1'b0, 8'hFF);
        send_item(1'b0, 8'hFF);
        send_item(1'b0, 8'hAA);
        send_item(1'b0, 8'h55);
        send_item(1'b1, 8'hFF);
        write_root(4'd2);
        send_item(1'b0, 8'hFF);
        send_item(1'b0, 8'h03);
        send_item(1'b0, 8'h03);
        send_item(1'b0, 8'h01);
        send_item(1'b1, 8'h00);
        send_item(1'b1, 8'h00);
        write_root(4'd0);
        send_item(1'b0, 8'h07);
        send_item(1'b1, 8'h00);
        write_root(4'd15);
        send_item(1'b0, 8'h80);
        send_item(1'b1, 8'h00);

        // long frame at root 8 runs past a full 255-byte sub-block
        write_root(4'd8);
        send_frame(250, 255);

        roots = '{4'd2, 4'd8, 4'd4, 4'd1, 4'd9, 4'd5};
        for (int f = 0; f < 5; f++) begin
            if (f == 4) quiet = 1;
            write_root(roots[f]);
            send_frame($urandom_range(1, 16), $urandom_range(0, 1) ? 255 : 3);
        end
        drain_all();
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
